// ===== rtl/core/tgr_pkg.sv =====
package tgr_pkg;

    // Defaults for the top-level parameters
    localparam int FONT_BYTES_DEF  = 8192;
    localparam int GLYPH_ROWS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed glyph width in pixels
    localparam int GLYPH_WIDTH = 8;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int FADDR_W  = 13;
    localparam int BYTE_W   = 8;
    localparam int OFF_W    = 32;
    localparam int SW_W     = 13;
    localparam int PITCH_W  = 14;
    localparam int STRIDE_W = 6;
    localparam int CX_W     = 13;
    localparam int CY_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Glyph base is char_code * glyph_stride
    localparam int BASE_W = CHAR_W + STRIDE_W;
    // Font address as carried in the queue, wide enough for the largest store
    localparam int JOB_ADDR_W = 14;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_DRAW    = 2'd1,
        CMD_NEWLINE = 2'd2,
        CMD_RSVD    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH = 2'd0,
        CFG_PITCH        = 2'd1,
        CFG_GLYPH_STRIDE = 2'd2,
        CFG_DRAW_COLOR   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DRAW = 1'b1
    } t_back_state;

    // One unit of work for the back end: a font store write or a glyph draw
    typedef struct packed {
        logic                  is_draw;
        logic [JOB_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]     data;
        logic [OFF_W-1:0]      off;
    } t_job;

endpackage

// ===== rtl/core/tgr_in_if.sv =====
interface tgr_in_if;
    import tgr_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  char_code;
    logic [FADDR_W-1:0] font_addr;
    logic [BYTE_W-1:0]  font_byte;

    modport source (output valid, output cmd, output char_code, output font_addr,
                    output font_byte, input ready);
    modport sink   (input valid, input cmd, input char_code, input font_addr,
                    input font_byte, output ready);
endinterface

// ===== rtl/core/tgr_out_if.sv =====
interface tgr_out_if;
    import tgr_pkg::*;

    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] pixel_offset;
    logic [BYTE_W-1:0] row_mask;
    logic             last;

    modport source (output valid, output pixel_offset, output row_mask, output last,
                    input ready);
    modport sink   (input valid, input pixel_offset, input row_mask, input last,
                    output ready);
endinterface

// ===== rtl/core/text_glyph_renderer_core.sv =====
// A draw item passes the job queue, the address register, the read stage and output register.
// A draw holds the back end for its dequeue plus one font read per row; font loads retire
// one per cycle while no draw is in progress; newline and the unused command take no
// back-end time. The rate is set by the single font store port, read once per glyph row.
// Reset (synchronous, active low): cursor at 0,0, queue and output empty, registers at
// screen_width 640, pitch 640, glyph_stride 16; the font store keeps its contents.
module text_glyph_renderer_core #(
    parameter int FONT_BYTES  = tgr_pkg::FONT_BYTES_DEF,
    parameter int GLYPH_ROWS  = tgr_pkg::GLYPH_ROWS_DEF,
    parameter int QUEUE_DEPTH = tgr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tgr_in_if.sink                        i_item,
    tgr_out_if.source                     o_row,
    input  logic                          i_cfg_we,
    input  logic [tgr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tgr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import tgr_pkg::*;

    // Configuration registers. The draw color is consumed by the pixel painter
    // downstream, so a write to its index is taken and dropped here.
    logic [SW_W-1:0]     r_screen_width;
    logic [PITCH_W-1:0]  r_pitch;
    logic [STRIDE_W-1:0] r_glyph_stride;

    // Queue between the front (cursor, address fold, offset multiply) and the
    // back (font store access and row emission)
    logic q_push, q_pop, q_full, q_empty;
    t_job q_wjob, q_rjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width <= SW_W'(640);
            r_pitch        <= PITCH_W'(640);
            r_glyph_stride <= STRIDE_W'(16);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCREEN_WIDTH: r_screen_width <= i_cfg_wdata[SW_W-1:0];
                CFG_PITCH:        r_pitch        <= i_cfg_wdata[PITCH_W-1:0];
                CFG_GLYPH_STRIDE: r_glyph_stride <= i_cfg_wdata[STRIDE_W-1:0];
                CFG_DRAW_COLOR: begin
                end
            endcase
        end
    end

    // Front: accept items, advance the cursor, turn loads and draws into jobs
    tgr_front #(
        .FONT_BYTES (FONT_BYTES),
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_screen_width (r_screen_width),
        .i_pitch        (r_pitch),
        .i_glyph_stride (r_glyph_stride),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_job        (q_wjob)
    );

    // Job queue keeps loads and draws in order so a draw sees exactly the
    // font bytes written before it
    tgr_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wjob),
        .i_pop   (q_pop),
        .o_rdata (q_rjob),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: own the font store, emit one row item per glyph row
    tgr_back #(
        .FONT_BYTES (FONT_BYTES),
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_job   (q_rjob),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pitch   (r_pitch),
        .o_row     (o_row)
    );
endmodule

// ===== rtl/core/tgr_ram.sv =====
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/tgr_fifo.sv =====
module tgr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_data[r_rd_ptr];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_wdata;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance on push");
endmodule

// ===== rtl/core/tgr_front.sv =====
module tgr_front #(
    parameter int FONT_BYTES = tgr_pkg::FONT_BYTES_DEF,
    parameter int GLYPH_ROWS = tgr_pkg::GLYPH_ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tgr_in_if.sink                       i_item,
    input  logic [tgr_pkg::SW_W-1:0]     i_screen_width,
    input  logic [tgr_pkg::PITCH_W-1:0]  i_pitch,
    input  logic [tgr_pkg::STRIDE_W-1:0] i_glyph_stride,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output tgr_pkg::t_job                o_q_job
);
    import tgr_pkg::*;

    localparam int FOLD_W = JOB_ADDR_W + 1;
    localparam int PROD_W = CY_W + PITCH_W;

    logic [CX_W-1:0] r_cursor_x, n_cursor_x;
    logic [CY_W-1:0] r_cursor_y, n_cursor_y;

    logic            accept;
    t_cmd            cmd;
    logic [BASE_W-1:0] base;
    logic [PROD_W-1:0] prod;
    logic [CX_W-1:0]   step_x;

    // Reduce a font address into the store; inputs stay below four store sizes
    function automatic logic [JOB_ADDR_W-1:0] fold(input logic [FOLD_W-1:0] v);
        logic [FOLD_W-1:0] t;
        t = v;
        for (int k = 0; k < 3; k++) begin
            if (t >= FOLD_W'(FONT_BYTES)) begin
                t = t - FOLD_W'(FONT_BYTES);
            end
        end
        fold = t[JOB_ADDR_W-1:0];
    endfunction

    assign i_item.ready = !i_q_full;
    assign accept = i_item.valid && !i_q_full;
    assign cmd    = t_cmd'(i_item.cmd);
    assign base   = BASE_W'(i_item.char_code) * BASE_W'(i_glyph_stride);
    assign prod   = PROD_W'(r_cursor_y) * PROD_W'(i_pitch);
    assign step_x = r_cursor_x + CX_W'(GLYPH_WIDTH);

    always_comb begin
        n_cursor_x       = r_cursor_x;
        n_cursor_y       = r_cursor_y;
        o_q_push         = 1'b0;
        o_q_job.is_draw  = 1'b0;
        o_q_job.addr     = fold(FOLD_W'(i_item.font_addr));
        o_q_job.data     = i_item.font_byte;
        o_q_job.off      = OFF_W'(prod) + OFF_W'(r_cursor_x);
        if (accept) begin
            unique case (cmd)
                CMD_LOAD: begin
                    o_q_push = 1'b1;
                end
                CMD_DRAW: begin
                    o_q_push        = 1'b1;
                    o_q_job.is_draw = 1'b1;
                    o_q_job.addr    = fold(FOLD_W'(base));
                    if ((SW_W + 1)'(step_x) + (SW_W + 1)'(GLYPH_WIDTH)
                            > (SW_W + 1)'(i_screen_width)) begin
                        n_cursor_x = '0;
                        n_cursor_y = r_cursor_y + CY_W'(GLYPH_ROWS);
                    end else begin
                        n_cursor_x = step_x;
                    end
                end
                CMD_NEWLINE: begin
                    n_cursor_x = '0;
                    n_cursor_y = r_cursor_y + CY_W'(GLYPH_ROWS);
                end
                CMD_RSVD: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
        end else begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
        end
    end
endmodule

// ===== rtl/core/tgr_back.sv =====
module tgr_back #(
    parameter int FONT_BYTES = tgr_pkg::FONT_BYTES_DEF,
    parameter int GLYPH_ROWS = tgr_pkg::GLYPH_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tgr_pkg::t_job               i_q_job,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    input  logic [tgr_pkg::PITCH_W-1:0] i_pitch,
    tgr_out_if.source                   o_row
);
    import tgr_pkg::*;

    localparam int AW = $clog2(FONT_BYTES);
    localparam int RW = $clog2(GLYPH_ROWS);

    t_back_state r_state, n_state;

    logic [AW-1:0]    r_addr;
    logic [OFF_W-1:0] r_off;
    logic [RW-1:0]    r_row;

    logic             r_s1_valid;
    logic [OFF_W-1:0] r_s1_off;
    logic             r_s1_last;

    logic             r_out_valid;
    logic [OFF_W-1:0] r_out_off;
    logic [BYTE_W-1:0] r_out_mask;
    logic             r_out_last;

    logic             out_free, s1_move, issue, row_last, start;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [BYTE_W-1:0] ram_rdata;

    assign out_free = !r_out_valid || o_row.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign row_last = (r_row == RW'(GLYPH_ROWS - 1));

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        ram_we   = 1'b0;
        issue    = 1'b0;
        start    = 1'b0;
        ram_addr = r_addr;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_job.is_draw) begin
                        start   = 1'b1;
                        n_state = ST_DRAW;
                    end else begin
                        ram_we   = 1'b1;
                        ram_addr = i_q_job.addr[AW-1:0];
                    end
                end
            end
            ST_DRAW: begin
                issue = !r_s1_valid || out_free;
                if (issue && row_last) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_row.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_addr <= i_q_job.addr[AW-1:0];
            r_off  <= i_q_job.off;
            r_row  <= '0;
        end else if (issue) begin
            r_addr <= (r_addr == AW'(FONT_BYTES - 1)) ? '0 : r_addr + 1'b1;
            r_off  <= r_off + OFF_W'(i_pitch);
            r_row  <= r_row + 1'b1;
        end
        if (issue) begin
            r_s1_off  <= r_off;
            r_s1_last <= row_last;
        end
        if (s1_move) begin
            r_out_off  <= r_s1_off;
            r_out_mask <= ram_rdata;
            r_out_last <= r_s1_last;
        end
    end

    tgr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FONT_BYTES)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (issue),
        .i_addr  (ram_addr),
        .i_wdata (i_q_job.data),
        .o_rdata (ram_rdata)
    );

    assign o_row.valid        = r_out_valid;
    assign o_row.pixel_offset = r_out_off;
    assign o_row.row_mask     = r_out_mask;
    assign o_row.last         = r_out_last;

    a_no_write_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW) |-> !ram_we)
        else $error("font write during a draw");

    a_last_row_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && row_last) |=> (r_state == ST_IDLE) && r_s1_last)
        else $error("draw did not end after its last row");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> r_s1_valid && $stable(r_s1_off))
        else $error("read stage lost a row under stall");
endmodule
